### rtl/ffsa_pkg.sv
package ffsa_pkg;

  // Default sizing of the segment table and the address space.
  localparam int unsigned MAX_SEGMENTS_DEF = 16;
  localparam int unsigned ADDR_BITS_DEF    = 16;

  // Fixed field widths of the channels and the configuration port.
  localparam int unsigned FIELD_BITS   = 16;
  localparam int unsigned CMD_BITS     = 2;
  localparam int unsigned STAT_BITS    = 2;
  localparam int unsigned CFG_IDX_BITS = 1;

  // Request commands.
  localparam logic [CMD_BITS-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_INIT  = 2'd2;

  // Result status codes.
  localparam logic [STAT_BITS-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_BITS-1:0] STAT_NOFIT = 2'd1;
  localparam logic [STAT_BITS-1:0] STAT_FULL  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_POOL_BASE = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POOL_SIZE = 1'd1;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_REJECT,
    OP_FULL,
    OP_SCAN_RD,
    OP_NEXT,
    OP_ALLOC_HIT,
    OP_MERGE_PREV,
    OP_MERGE_NEXT,
    OP_SHDN_RD,
    OP_SHDN_WR,
    OP_SHDN_END,
    OP_SHUP_START,
    OP_SHUP_RD,
    OP_SHUP_WR,
    OP_INSERT,
    OP_DELIVER
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  // Conditions reported by the datapath.
  typedef struct packed {
    logic [CMD_BITS-1:0] cmd;
    logic                n_zero;
    logic                outside;
    logic                idx_lt_cnt;
    logic                fit;
    logic                before_end;
    logic                join_prev;
    logic                join_next;
    logic                full;
    logic                newlen_zero;
    logic                shdn_more;
    logic                shup_more;
  } dp_stat_t;

endpackage

### rtl/ffsa_req_if.sv
interface ffsa_req_if;
  logic                                valid;
  logic                                ready;
  logic [ffsa_pkg::CMD_BITS-1:0]       cmd;
  logic [ffsa_pkg::FIELD_BITS-1:0]     address;
  logic [ffsa_pkg::FIELD_BITS-1:0]     length;

  modport source (output valid, cmd, address, length, input ready);
  modport sink (input valid, cmd, address, length, output ready);
endinterface

### rtl/ffsa_rsp_if.sv
interface ffsa_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [ffsa_pkg::STAT_BITS-1:0]      status;
  logic [ffsa_pkg::FIELD_BITS-1:0]     granted_address;

  modport source (output valid, status, granted_address, input ready);
  modport sink (input valid, status, granted_address, output ready);
endinterface

### rtl/ffsa_datapath.sv
module ffsa_datapath #(
  parameter int unsigned MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned ADDR_BITS    = ffsa_pkg::ADDR_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ffsa_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [ffsa_pkg::FIELD_BITS-1:0]     cfg_wdata_i,
  input  logic [ffsa_pkg::CMD_BITS-1:0]       req_cmd_i,
  input  logic [ffsa_pkg::FIELD_BITS-1:0]     req_address_i,
  input  logic [ffsa_pkg::FIELD_BITS-1:0]     req_length_i,
  input  ffsa_pkg::dp_cmd_t                   ctl_i,
  output ffsa_pkg::dp_stat_t                  stat_o,
  output logic [ffsa_pkg::STAT_BITS-1:0]      out_status_o,
  output logic [ffsa_pkg::FIELD_BITS-1:0]     out_gaddr_o
);

  localparam int unsigned IW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned AW = $clog2(MAX_SEGMENTS);
  localparam int unsigned LW = ADDR_BITS + 1;
  localparam int unsigned FB = ffsa_pkg::FIELD_BITS;
  localparam int unsigned WW = ((ADDR_BITS > FB) ? ADDR_BITS : FB) + 1;

  // Segment table memory with registered read data.
  logic [ADDR_BITS-1:0] mem_start [MAX_SEGMENTS];
  logic [LW-1:0]        mem_len   [MAX_SEGMENTS];
  logic [ADDR_BITS-1:0] rd_start_q;
  logic [LW-1:0]        rd_len_q;

  logic [FB-1:0]        base_q, size_q;
  logic [IW-1:0]        cnt_q, cnt_d;
  logic [IW-1:0]        idx_q, ptr_q;
  logic [ffsa_pkg::CMD_BITS-1:0]  cmd_q;
  logic [ADDR_BITS-1:0] a_q;
  logic [FB-1:0]        n_q;
  logic [ADDR_BITS-1:0] prev_start_q;
  logic [LW-1:0]        prev_len_q;
  logic [ffsa_pkg::STAT_BITS-1:0] status_q, out_status_q;
  logic [FB-1:0]        gaddr_q, out_gaddr_q;

  logic [ADDR_BITS-1:0] base_a;
  logic [WW-1:0]        pend_raw, span, pend, a_w, end_w, gaddr_w, n_w, len_w;
  logic [LW-1:0]        end_l, rd_end, prev_end, e_prev, e_next, newlen;
  logic [IW-1:0]        idx_p1, idx_m1, ptr_m1;
  logic                 join_prev, join_next, idx_lt_cnt;

  logic                 we, re;
  logic [AW-1:0]        waddr, raddr;
  logic [ADDR_BITS-1:0] wstart;
  logic [LW-1:0]        wlen;

  // Pool bounds, saturated at the top of the address space.
  always_comb begin
    base_a   = ADDR_BITS'(base_q);
    pend_raw = WW'(base_a) + WW'(size_q);
    span     = WW'(1) << ADDR_BITS;
    pend     = (pend_raw > span) ? span : pend_raw;
  end

  // Request arithmetic and comparisons.
  always_comb begin
    a_w        = WW'(a_q);
    n_w        = WW'(n_q);
    len_w      = WW'(rd_len_q);
    end_w      = a_w + n_w;
    end_l      = LW'(end_w);
    rd_end     = LW'(rd_start_q) + rd_len_q;
    prev_end   = LW'(prev_start_q) + prev_len_q;
    gaddr_w    = WW'(rd_start_q) + len_w - n_w;
    newlen     = LW'(len_w - n_w);
    idx_p1     = idx_q + IW'(1);
    idx_m1     = idx_q - IW'(1);
    ptr_m1     = ptr_q - IW'(1);
    idx_lt_cnt = idx_q < cnt_q;
    join_prev  = (idx_q != '0) && (prev_end >= LW'(a_q));
    join_next  = idx_lt_cnt && (end_l >= LW'(rd_start_q));
    e_prev     = (prev_end > end_l) ? prev_end : end_l;
    if (join_next && (rd_end > e_prev)) begin
      e_prev = rd_end;
    end
    e_next     = (rd_end > end_l) ? rd_end : end_l;
  end

  // Conditions for the controller.
  always_comb begin
    stat_o.cmd         = cmd_q;
    stat_o.n_zero      = (n_q == '0);
    stat_o.outside     = (a_w < WW'(base_a)) || (a_w >= pend) || (end_w > pend);
    stat_o.idx_lt_cnt  = idx_lt_cnt;
    stat_o.fit         = len_w >= n_w;
    stat_o.before_end  = LW'(rd_start_q) < end_l;
    stat_o.join_prev   = join_prev;
    stat_o.join_next   = join_next;
    stat_o.full        = (cnt_q == IW'(MAX_SEGMENTS));
    stat_o.newlen_zero = (newlen == '0);
    stat_o.shdn_more   = idx_p1 < cnt_q;
    stat_o.shup_more   = ptr_q > idx_q;
  end

  // Memory port selection per operation.
  always_comb begin
    we     = 1'b0;
    re     = 1'b0;
    waddr  = idx_q[AW-1:0];
    raddr  = idx_q[AW-1:0];
    wstart = rd_start_q;
    wlen   = rd_len_q;
    case (ctl_i.op)
      ffsa_pkg::OP_INIT: begin
        we     = pend > WW'(base_a);
        waddr  = '0;
        wstart = base_a;
        wlen   = LW'(pend - WW'(base_a));
      end
      ffsa_pkg::OP_SCAN_RD: begin
        re = 1'b1;
      end
      ffsa_pkg::OP_ALLOC_HIT: begin
        we   = (newlen != '0);
        wlen = newlen;
      end
      ffsa_pkg::OP_MERGE_PREV: begin
        we     = 1'b1;
        waddr  = idx_m1[AW-1:0];
        wstart = prev_start_q;
        wlen   = e_prev - LW'(prev_start_q);
      end
      ffsa_pkg::OP_MERGE_NEXT: begin
        we     = 1'b1;
        wstart = a_q;
        wlen   = e_next - LW'(a_q);
      end
      ffsa_pkg::OP_SHDN_RD: begin
        re    = 1'b1;
        raddr = idx_p1[AW-1:0];
      end
      ffsa_pkg::OP_SHDN_WR: begin
        we = 1'b1;
      end
      ffsa_pkg::OP_SHUP_RD: begin
        re    = 1'b1;
        raddr = ptr_m1[AW-1:0];
      end
      ffsa_pkg::OP_SHUP_WR: begin
        we    = 1'b1;
        waddr = ptr_q[AW-1:0];
      end
      ffsa_pkg::OP_INSERT: begin
        we     = 1'b1;
        wstart = a_q;
        wlen   = LW'(n_q);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Segment table storage.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_start[waddr] <= wstart;
      mem_len[waddr]   <= wlen;
    end
    if (re) begin
      rd_start_q <= mem_start[raddr];
      rd_len_q   <= mem_len[raddr];
    end
  end

  // Segment count update.
  always_comb begin
    cnt_d = cnt_q;
    case (ctl_i.op)
      ffsa_pkg::OP_INIT:     cnt_d = (pend > WW'(base_a)) ? IW'(1) : '0;
      ffsa_pkg::OP_SHDN_END: cnt_d = cnt_q - IW'(1);
      ffsa_pkg::OP_INSERT:   cnt_d = cnt_q + IW'(1);
      default:               cnt_d = cnt_q;
    endcase
  end

  // Configuration registers and segment count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      size_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i && (cfg_idx_i == ffsa_pkg::CFG_POOL_BASE)) begin
        base_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == ffsa_pkg::CFG_POOL_SIZE)) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  // Request registers, scan pointers and result.
  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      ffsa_pkg::OP_LOAD: begin
        cmd_q    <= req_cmd_i;
        a_q      <= ADDR_BITS'(req_address_i);
        n_q      <= req_length_i;
        idx_q    <= '0;
        status_q <= ffsa_pkg::STAT_OK;
        gaddr_q  <= '0;
      end
      ffsa_pkg::OP_REJECT:    status_q <= ffsa_pkg::STAT_NOFIT;
      ffsa_pkg::OP_FULL:      status_q <= ffsa_pkg::STAT_FULL;
      ffsa_pkg::OP_NEXT: begin
        prev_start_q <= rd_start_q;
        prev_len_q   <= rd_len_q;
        idx_q        <= idx_p1;
      end
      ffsa_pkg::OP_ALLOC_HIT: gaddr_q <= gaddr_w[FB-1:0];
      ffsa_pkg::OP_SHDN_WR:   idx_q   <= idx_p1;
      ffsa_pkg::OP_SHUP_START: ptr_q  <= cnt_q;
      ffsa_pkg::OP_SHUP_WR:   ptr_q   <= ptr_m1;
      ffsa_pkg::OP_DELIVER: begin
        out_status_q <= status_q;
        out_gaddr_q  <= gaddr_q;
      end
      default: begin
        idx_q <= idx_q;
      end
    endcase
  end

  assign out_status_o = out_status_q;
  assign out_gaddr_o  = out_gaddr_q;

endmodule

### rtl/ffsa_ctrl.sv
module ffsa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  ffsa_pkg::dp_stat_t stat_i,
  output ffsa_pkg::dp_cmd_t  ctl_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_EVAL,
    S_DECIDE,
    S_SHDN,
    S_SHDN_W,
    S_SHUP,
    S_SHUP_W,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   is_alloc;

  assign is_alloc    = (stat_i.cmd == ffsa_pkg::CMD_ALLOC);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and datapath operation.
  always_comb begin
    state_d     = state_q;
    ctl_o.op    = ffsa_pkg::OP_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.op = ffsa_pkg::OP_LOAD;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_DONE;
        case (stat_i.cmd)
          ffsa_pkg::CMD_ALLOC: begin
            if (stat_i.n_zero) begin
              ctl_o.op = ffsa_pkg::OP_REJECT;
            end else begin
              state_d = S_SCAN;
            end
          end
          ffsa_pkg::CMD_FREE: begin
            if (stat_i.outside) begin
              ctl_o.op = ffsa_pkg::OP_REJECT;
            end else if (!stat_i.n_zero) begin
              state_d = S_SCAN;
            end
          end
          ffsa_pkg::CMD_INIT: ctl_o.op = ffsa_pkg::OP_INIT;
          default:            ctl_o.op = ffsa_pkg::OP_REJECT;
        endcase
      end
      S_SCAN: begin
        if (stat_i.idx_lt_cnt) begin
          ctl_o.op = ffsa_pkg::OP_SCAN_RD;
          state_d  = S_EVAL;
        end else if (is_alloc) begin
          ctl_o.op = ffsa_pkg::OP_REJECT;
          state_d  = S_DONE;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_EVAL: begin
        if (is_alloc) begin
          if (stat_i.fit) begin
            ctl_o.op = ffsa_pkg::OP_ALLOC_HIT;
            state_d  = stat_i.newlen_zero ? S_SHDN : S_DONE;
          end else begin
            ctl_o.op = ffsa_pkg::OP_NEXT;
            state_d  = S_SCAN;
          end
        end else if (stat_i.before_end) begin
          ctl_o.op = ffsa_pkg::OP_NEXT;
          state_d  = S_SCAN;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat_i.join_prev) begin
          ctl_o.op = ffsa_pkg::OP_MERGE_PREV;
          state_d  = stat_i.join_next ? S_SHDN : S_DONE;
        end else if (stat_i.join_next) begin
          ctl_o.op = ffsa_pkg::OP_MERGE_NEXT;
          state_d  = S_DONE;
        end else if (stat_i.full) begin
          ctl_o.op = ffsa_pkg::OP_FULL;
          state_d  = S_DONE;
        end else begin
          ctl_o.op = ffsa_pkg::OP_SHUP_START;
          state_d  = S_SHUP;
        end
      end
      S_SHDN: begin
        if (stat_i.shdn_more) begin
          ctl_o.op = ffsa_pkg::OP_SHDN_RD;
          state_d  = S_SHDN_W;
        end else begin
          ctl_o.op = ffsa_pkg::OP_SHDN_END;
          state_d  = S_DONE;
        end
      end
      S_SHDN_W: begin
        ctl_o.op = ffsa_pkg::OP_SHDN_WR;
        state_d  = S_SHDN;
      end
      S_SHUP: begin
        if (stat_i.shup_more) begin
          ctl_o.op = ffsa_pkg::OP_SHUP_RD;
          state_d  = S_SHUP_W;
        end else begin
          ctl_o.op = ffsa_pkg::OP_INSERT;
          state_d  = S_DONE;
        end
      end
      S_SHUP_W: begin
        ctl_o.op = ffsa_pkg::OP_SHUP_WR;
        state_d  = S_SHUP;
      end
      S_DONE: begin
        // Load the output register once it is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          ctl_o.op    = ffsa_pkg::OP_DELIVER;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and output valid register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/first_fit_segment_allocator_top.sv
// First-fit free-segment allocator with coalescing.
// Requests arrive on the req channel (cmd, address, length) and each one
// yields exactly one result on the rsp channel (status, granted_address).
// Commands: allocate takes the first free segment that is large enough and
// carves the request from its top end; free returns a range to the table
// and merges it with its neighbors; init makes the whole pool one segment.
// The pool is set through the write port: index 0 pool base, 1 pool size.
// Write it only while no request is in flight.
// One request is worked on at a time. The controller walks the segment
// table through a memory with one read and one write port, one entry at a
// time, both to examine entries and to move them when one is inserted or
// removed. The next request is accepted at the earliest in the cycle after
// the result register is loaded.
// The result sits in an output register, so a new request is taken while
// an earlier result still waits; a stalled receiver holds the next result
// back in the controller, and then no further request is taken.
// Reset empties the table and clears the pool base and size to zero.
module first_fit_segment_allocator_top #(
  parameter int unsigned MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned ADDR_BITS    = ffsa_pkg::ADDR_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ffsa_req_if.sink                          req,
  ffsa_rsp_if.source                        rsp,
  input  logic                              cfg_we_i,
  input  logic [ffsa_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [ffsa_pkg::FIELD_BITS-1:0]   cfg_wdata_i
);

  ffsa_pkg::dp_cmd_t  ctl;
  ffsa_pkg::dp_stat_t stat;

  // Sequencer.
  ffsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  // Segment table and arithmetic.
  ffsa_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_cmd_i     (req.cmd),
    .req_address_i (req.address),
    .req_length_i  (req.length),
    .ctl_i         (ctl),
    .stat_o        (stat),
    .out_status_o  (rsp.status),
    .out_gaddr_o   (rsp.granted_address)
  );

endmodule

### rtl/ffsa_checker.sv
module ffsa_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [ffsa_pkg::STAT_BITS-1:0]     status,
  input logic [ffsa_pkg::FIELD_BITS-1:0]    granted_address
);

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(granted_address))
    else $error("result changed while stalled");

  // A failed request always reports a zero granted address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (status != ffsa_pkg::STAT_OK) |-> granted_address == '0)
    else $error("address granted on a failed request");

  // One request at a time: the request side closes after an acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  // The reserved status code never appears.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (status == ffsa_pkg::STAT_OK) || (status == ffsa_pkg::STAT_NOFIT) ||
                  (status == ffsa_pkg::STAT_FULL))
    else $error("invalid status code");

endmodule

bind first_fit_segment_allocator_top ffsa_checker u_ffsa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid        (req.valid),
  .in_ready        (req.ready),
  .out_valid       (rsp.valid),
  .out_ready       (rsp.ready),
  .status          (rsp.status),
  .granted_address (rsp.granted_address)
);

### tb/ffsa_alloc_checker.sv
`timescale 1ns / 100ps

// Watches the request and result channels, keeps its own copy of the
// free-segment table and checks every result against the predicted one.
module ffsa_alloc_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ffsa_req_if                               req,
  ffsa_rsp_if                               rsp,
  input  logic                              cfg_we_i,
  input  logic [ffsa_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [ffsa_pkg::FIELD_BITS-1:0]   cfg_wdata_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                checked_o
);

  localparam int unsigned TABLE_DEPTH = ffsa_pkg::MAX_SEGMENTS_DEF;
  localparam longint     ADDR_SPAN   = 64'd1 << ffsa_pkg::ADDR_BITS_DEF;

  typedef struct packed {
    logic [ffsa_pkg::STAT_BITS-1:0]  status;
    logic [ffsa_pkg::FIELD_BITS-1:0] granted_address;
  } alloc_result_t;

  alloc_result_t expected_results[$];

  // Shadow copy of the pool registers and the free-segment table.
  logic [15:0] pool_base_q;
  logic [15:0] pool_size_q;
  longint      seg_start[TABLE_DEPTH];
  longint      seg_len[TABLE_DEPTH];
  int          seg_cnt;

  function automatic longint pool_end();
    longint e;
    e = longint'(pool_base_q) + longint'(pool_size_q);
    return (e > ADDR_SPAN) ? ADDR_SPAN : e;
  endfunction

  function automatic void drop_segment(int p);
    for (int i = p; i + 1 < seg_cnt; i++) begin
      seg_start[i] = seg_start[i+1];
      seg_len[i]   = seg_len[i+1];
    end
    seg_cnt--;
  endfunction

  // First fit, carved from the top end of the segment.
  function automatic alloc_result_t predict_alloc(longint n);
    alloc_result_t r;
    r = '{status: ffsa_pkg::STAT_NOFIT, granted_address: '0};
    if (n == 0) return r;
    for (int i = 0; i < seg_cnt; i++) begin
      if (seg_len[i] >= n) begin
        r.status          = ffsa_pkg::STAT_OK;
        r.granted_address = 16'(seg_start[i] + seg_len[i] - n);
        seg_len[i]        = seg_len[i] - n;
        if (seg_len[i] == 0) drop_segment(i);
        return r;
      end
    end
    return r;
  endfunction

  // Insert a freed range in address order and merge with its neighbors.
  function automatic logic [ffsa_pkg::STAT_BITS-1:0] predict_free(longint a, longint n);
    longint pend, rend, e;
    int     p;
    bit     join_next, join_prev;
    pend = pool_end();
    rend = a + n;
    p    = 0;
    if (a < longint'(pool_base_q) || a >= pend || rend > pend) return ffsa_pkg::STAT_NOFIT;
    if (n == 0) return ffsa_pkg::STAT_OK;
    while (p < seg_cnt && seg_start[p] < rend) p++;
    join_next = (p < seg_cnt) && (rend >= seg_start[p]);
    join_prev = (p > 0) && (seg_start[p-1] + seg_len[p-1] >= a);
    if (join_prev) begin
      e = seg_start[p-1] + seg_len[p-1];
      if (rend > e) e = rend;
      if (join_next && seg_start[p] + seg_len[p] > e) e = seg_start[p] + seg_len[p];
      seg_len[p-1] = e - seg_start[p-1];
      if (join_next) drop_segment(p);
    end else if (join_next) begin
      e = seg_start[p] + seg_len[p];
      if (rend > e) e = rend;
      seg_start[p] = a;
      seg_len[p]   = e - a;
    end else begin
      if (seg_cnt >= TABLE_DEPTH) return ffsa_pkg::STAT_FULL;
      for (int i = seg_cnt; i > p; i--) begin
        seg_start[i] = seg_start[i-1];
        seg_len[i]   = seg_len[i-1];
      end
      seg_start[p] = a;
      seg_len[p]   = n;
      seg_cnt++;
    end
    return ffsa_pkg::STAT_OK;
  endfunction

  function automatic alloc_result_t predict_request(logic [ffsa_pkg::CMD_BITS-1:0] c,
                                                    logic [15:0] a, logic [15:0] n);
    alloc_result_t r;
    longint pend;
    r = '{status: ffsa_pkg::STAT_NOFIT, granted_address: '0};
    case (c)
      ffsa_pkg::CMD_ALLOC: r = predict_alloc(longint'(n));
      ffsa_pkg::CMD_FREE:  r.status = predict_free(longint'(a), longint'(n));
      ffsa_pkg::CMD_INIT: begin
        pend    = pool_end();
        seg_cnt = 0;
        if (pend > longint'(pool_base_q)) begin
          seg_start[0] = pool_base_q;
          seg_len[0]   = pend - longint'(pool_base_q);
          seg_cnt      = 1;
        end
        r.status = ffsa_pkg::STAT_OK;
      end
      default: r.status = ffsa_pkg::STAT_NOFIT;
    endcase
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // Results are checked before the request of the same edge is predicted,
  // since a result always belongs to an earlier request.
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want;
    if (!rst_ni) begin
      pool_base_q = '0;
      pool_size_q = '0;
      seg_cnt     = 0;
      expected_results.delete();
      fail_count_o = 0;
      checked_o    = 0;
      pending_o    = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected result status", rsp.status, 0);
        end else begin
          want = expected_results.pop_front();
          checked_o++;
          if (rsp.status !== want.status)
            report("status", rsp.status, want.status);
          if (rsp.granted_address !== want.granted_address)
            report("granted_address", rsp.granted_address, want.granted_address);
        end
      end
      if (req.valid && req.ready)
        expected_results.push_back(predict_request(req.cmd, req.address, req.length));
      if (cfg_we_i) begin
        if (cfg_idx_i == ffsa_pkg::CFG_POOL_BASE) pool_base_q = cfg_wdata_i;
        else pool_size_q = cfg_wdata_i;
      end
      pending_o = expected_results.size();
    end
  end

endmodule

### tb/first_fit_segment_allocator_top_tb.sv
`timescale 1ns / 100ps

module first_fit_segment_allocator_top_tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 4 * ffsa_pkg::MAX_SEGMENTS_DEF + 16;
  localparam int PHASES         = 8;
  localparam int RANDOM_PER_PHASE = 211;

  // Command code that the block does not define.
  localparam logic [ffsa_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ffsa_pkg::CFG_IDX_BITS-1:0] cfg_idx_i = ffsa_pkg::CFG_POOL_BASE;
  logic [ffsa_pkg::FIELD_BITS-1:0] cfg_wdata_i = '0;

  int fail_count, pending, checked;
  int send_idle_pct, recv_stall_pct;
  int idle_cycles;
  int cmd_counts[4];
  logic req_fire;
  int cur_base, cur_size;

  ffsa_req_if req();
  ffsa_rsp_if rsp();

  first_fit_segment_allocator_top dut (
    .clk_i, .rst_ni, .req(req.sink), .rsp(rsp.source),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  ffsa_alloc_checker checker_i (
    .clk_i, .rst_ni, .req(req), .rsp(rsp),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    req.valid   = 1'b0;
    req.cmd     = ffsa_pkg::CMD_ALLOC;
    req.address = '0;
    req.length  = '0;
    rsp.ready   = 1'b0;
  end

  // Acceptance seen at the last rising edge, read by the driver at the falling one.
  always @(posedge clk_i) req_fire <= req.valid && req.ready;

  // The receiver stalls at random according to the current phase.
  always @(negedge clk_i) rsp.ready <= ($urandom_range(99) >= recv_stall_pct);

  // Watchdog on cycles in which nothing is accepted.
  always @(posedge clk_i) begin
    if (!rst_ni || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding.", pending);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(logic [ffsa_pkg::CMD_BITS-1:0] c, int a, int n);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid   <= 1'b1;
    req.cmd     <= c;
    req.address <= 16'(a);
    req.length  <= 16'(n);
    cmd_counts[c]++;
    do @(negedge clk_i); while (!req_fire);
  endtask

  // Waits until every request has its result and the block is quiet.
  task automatic drain();
    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_pool(int base, int size);
    cur_base = base;
    cur_size = size;
    cfg_we_i <= 1'b1; cfg_idx_i <= ffsa_pkg::CFG_POOL_BASE; cfg_wdata_i <= 16'(base);
    @(negedge clk_i);
    cfg_idx_i <= ffsa_pkg::CFG_POOL_SIZE; cfg_wdata_i <= 16'(size);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Mostly allocations and frees sized to the pool, with some noise.
  task automatic random_request();
    int pick, pend, a, span, lim;
    pick = $urandom_range(99);
    pend = cur_base + cur_size;
    if (pend > 65536) pend = 65536;
    span = (cur_size / 8 > 1) ? cur_size / 8 : 1;
    if (pick < 42) begin
      send_request(ffsa_pkg::CMD_ALLOC, $urandom, $urandom_range(span, 1));
    end else if (pick < 86 && pend > cur_base) begin
      a   = $urandom_range(pend - 1, cur_base);
      lim = (pend - a < span) ? pend - a : span;
      send_request(ffsa_pkg::CMD_FREE, a, $urandom_range(lim, 0));
    end else if (pick < 90) begin
      send_request(ffsa_pkg::CMD_INIT, $urandom, $urandom);
    end else begin
      send_request(ffsa_pkg::CMD_FREE, $urandom, $urandom);
      send_request(2'($urandom_range(3)), $urandom, $urandom);
    end
  endtask

  initial begin
    int base, size;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cur_base = 0;
    cur_size = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: empty pool after reset, then edge cases in a small pool.
    send_request(ffsa_pkg::CMD_INIT, 0, 0);
    send_request(ffsa_pkg::CMD_ALLOC, 0, 1);
    drain();
    set_pool(16'h0100, 16'h0400);
    send_request(ffsa_pkg::CMD_INIT, 0, 0);
    send_request(ffsa_pkg::CMD_ALLOC, 0, 0);
    send_request(ffsa_pkg::CMD_ALLOC, 0, 16'h0010);
    send_request(ffsa_pkg::CMD_ALLOC, 0, 16'h0500);
    send_request(ffsa_pkg::CMD_FREE, 16'h04F0, 16'h0010);
    send_request(ffsa_pkg::CMD_FREE, 16'h0050, 4);
    send_request(ffsa_pkg::CMD_FREE, 16'h0500, 1);
    send_request(ffsa_pkg::CMD_FREE, 16'h04FF, 2);
    send_request(ffsa_pkg::CMD_FREE, 16'h0200, 0);
    send_request(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
    send_request(ffsa_pkg::CMD_ALLOC, 0, 16'h0400);
    send_request(ffsa_pkg::CMD_ALLOC, 0, 1);
    send_request(ffsa_pkg::CMD_FREE, 16'h0200, 16'h0010);
    send_request(ffsa_pkg::CMD_FREE, 16'h0210, 16'h0008);
    send_request(ffsa_pkg::CMD_FREE, 16'h01F0, 16'h0010);
    send_request(ffsa_pkg::CMD_FREE, 16'h0205, 16'h0040);
    // Fill the table until a free finds it full.
    for (int i = 0; i < ffsa_pkg::MAX_SEGMENTS_DEF; i++) begin
      send_request(ffsa_pkg::CMD_FREE, 16'h0300 + 8 * i, 2);
    end
    drain();
    // Pool that runs past the end of the address space.
    set_pool(16'hFFFF, 16'hFFFF);
    send_request(ffsa_pkg::CMD_INIT, 0, 0);
    send_request(ffsa_pkg::CMD_ALLOC, 0, 1);
    send_request(ffsa_pkg::CMD_FREE, 16'hFFFF, 1);
    drain();
    set_pool(0, 16'hFFFF);
    send_request(ffsa_pkg::CMD_INIT, 0, 0);
    send_request(ffsa_pkg::CMD_ALLOC, 0, 16'hFFFF);
    send_request(ffsa_pkg::CMD_FREE, 0, 16'hFFFF);
    drain();

    // Random part over several pools and idle patterns.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      case (ph)
        0: begin base = 0;                       size = 16'hFFFF; end
        1: begin base = 16'hFFFF;                size = 16'hFFFF; end
        2: begin base = 16'h8000;                size = 64;       end
        3: begin base = 0;                       size = 0;        end
        4: begin base = 16'hF000;                size = 16'h2000; end
        default: begin base = $urandom_range(16'hFFFF); size = $urandom_range(16'h0FFF, 16); end
      endcase
      set_pool(base, size);
      send_request(ffsa_pkg::CMD_INIT, 0, 0);
      for (int k = 0; k < RANDOM_PER_PHASE; k++) random_request();
      drain();
    end

    $display("Checked %0d results for %0d allocate, %0d free, %0d init, %0d unused requests,",
             checked, cmd_counts[ffsa_pkg::CMD_ALLOC], cmd_counts[ffsa_pkg::CMD_FREE],
             cmd_counts[ffsa_pkg::CMD_INIT], cmd_counts[CMD_UNUSED]);
    $display("across %0d pool settings and four idle and stall patterns.", PHASES + 4);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### first_fit_segment_allocator_top.f
rtl/ffsa_pkg.sv
rtl/ffsa_req_if.sv
rtl/ffsa_rsp_if.sv
rtl/ffsa_datapath.sv
rtl/ffsa_ctrl.sv
rtl/first_fit_segment_allocator_top.sv
rtl/ffsa_checker.sv
tb/ffsa_alloc_checker.sv
tb/first_fit_segment_allocator_top_tb.sv
